// ===== rtl/hbs_pkg.sv =====
// Shared constants and types for the heightmap bilinear sampler.
package hbs_pkg;

  // Grid and field geometry (both powers of two)
  localparam int GRID_SIZE   = 256;
  localparam int FIELD_SIDE  = 1024;
  localparam int GRID_BITS   = $clog2(GRID_SIZE);
  localparam int FIELD_SHIFT = $clog2(FIELD_SIDE);
  localparam int CELL_COUNT  = GRID_SIZE * GRID_SIZE;

  // Field widths
  localparam int IDX_W  = 16;
  localparam int HGT_W  = 24;
  localparam int FRAC_W = 8;

  // Grid position in Q.8, and the clamped numerator of the mapping
  localparam int POS_W  = GRID_BITS + FRAC_W;
  localparam int NUM_W  = FIELD_SHIFT + FRAC_W;
  localparam int PROD_W = NUM_W + GRID_BITS;
  localparam int SUM_W  = HGT_W + 1;

  // Four banks split by row and column parity
  localparam int BANKS      = 4;
  localparam int BANK_SEL_W = 2;
  localparam int BANK_AW    = 2 * (GRID_BITS - 1);
  localparam int BANK_DEPTH = CELL_COUNT / BANKS;

  // Blend widths
  localparam int ROW_W  = HGT_W + FRAC_W;
  localparam int FULL_W = ROW_W + FRAC_W + 2;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Parity of the near and far column and row, picks the bank per corner
  typedef struct packed {
    logic x0;
    logic x1;
    logic z0;
    logic z1;
  } sel_t;

endpackage

// ===== rtl/heightmap_bilinear_sampler.sv =====
// Heightmap bilinear sampler: banked height grid, four-stage query pipeline.
//
//   channel | signals                                         | dir
//   --------+-------------------------------------------------+-----
//   cfg     | cfg_we, cfg_data (flat_mode)                    | in
//   in      | in_valid/in_ready, op, sample_index,            | in
//           | sample_height, pos_x, pos_z                     |
//   out     | out_valid/out_ready, height, defaulted          | out
//
// One word per cycle unless a stall holds the pipeline; a query result passes the input
// stage, bank read, row blend and column blend/output register in order before it is shown.
// Writes update the bank in the read stage, so later queries see them in order.
// Stalls propagate backward stage by stage; empty stages keep filling.
// Reset clears stage valids, grid_ready and flat_mode; the grid is not cleared.
module heightmap_bilinear_sampler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic        [hbs_pkg::IDX_W-1:0]    sample_index,
  input  logic signed [hbs_pkg::HGT_W-1:0]    sample_height,
  input  logic signed [hbs_pkg::HGT_W-1:0]    pos_x,
  input  logic signed [hbs_pkg::HGT_W-1:0]    pos_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hbs_pkg::HGT_W-1:0]    height,
  output logic                                defaulted
);
  import hbs_pkg::*;

  // Map a world coordinate onto the grid in Q.8, clamped to the edges
  function automatic logic [POS_W-1:0] grid_pos(input logic signed [HGT_W-1:0] coord);
    logic signed [SUM_W-1:0] num;
    logic        [PROD_W-1:0] prod;
    logic        [PROD_W-1:0] scaled;
    num = SUM_W'(coord) + SUM_W'(FIELD_SIDE * 128);
    prod = PROD_W'(num[NUM_W-1:0]) * PROD_W'(GRID_SIZE - 1);
    scaled = prod >> FIELD_SHIFT;
    if (num <= 0) begin
      grid_pos = '0;
    end else if (num >= SUM_W'(FIELD_SIDE * 256)) begin
      grid_pos = POS_W'((GRID_SIZE - 1) * 256);
    end else begin
      grid_pos = scaled[POS_W-1:0];
    end
  endfunction

  logic flat_mode;
  logic grid_ready;

  logic en1, en2, en3, en4;

  // Stage 1: input register with grid positions
  logic                     s1_valid;
  logic                     s1_op;
  logic [IDX_W-1:0]         s1_idx;
  logic signed [HGT_W-1:0]  s1_wdata;
  logic [POS_W-1:0]         s1_sx;
  logic [POS_W-1:0]         s1_sz;

  // Stage 2: bank read data and blend controls
  logic                     s2_valid;
  logic                     s2_dflt;
  logic [FRAC_W-1:0]        s2_tx;
  logic [FRAC_W-1:0]        s2_tz;
  sel_t                     s2_sel;
  logic signed [HGT_W-1:0]  rd_data [BANKS];

  // Stage 3: row blends
  logic                     s3_valid;
  logic                     s3_dflt;
  logic [FRAC_W-1:0]        s3_tz;
  logic signed [ROW_W-1:0]  s3_r0;
  logic signed [ROW_W-1:0]  s3_r1;

  // Stage enables: a stage loads when empty or when it hands on its word
  assign en4 = !out_valid || out_ready;
  assign en3 = !s3_valid || en4;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign in_ready = en1;

  // Hold the flat-mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      flat_mode <= 1'b0;
    end else if (cfg_we) begin
      flat_mode <= cfg_data;
    end
  end

  // Capture the word and compute grid positions
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op    <= op;
      s1_idx   <= sample_index;
      s1_wdata <= sample_height;
      s1_sx    <= grid_pos(pos_x);
      s1_sz    <= grid_pos(pos_z);
    end
  end

  // Decode the write and the four read addresses
  logic [GRID_BITS-1:0]  wr_row, wr_col;
  logic [BANK_SEL_W-1:0] wr_bank;
  logic [BANK_AW-1:0]    wr_addr;
  logic                  wr_en;
  logic [GRID_BITS-1:0]  x0, x1, z0, z1;
  logic                  x_clamp, z_clamp;
  logic [GRID_BITS-1:0]  xc [2];
  logic [GRID_BITS-1:0]  zr [2];
  logic [BANK_AW-1:0]    rd_addr [BANKS];
  sel_t                  sel;

  always_comb begin
    wr_row  = s1_idx[2*GRID_BITS-1:GRID_BITS];
    wr_col  = s1_idx[GRID_BITS-1:0];
    wr_bank = {wr_row[0], wr_col[0]};
    wr_addr = {wr_row[GRID_BITS-1:1], wr_col[GRID_BITS-1:1]};
    wr_en   = en2 && s1_valid && (s1_op == OP_WRITE) && (32'(s1_idx) < CELL_COUNT);

    x0 = s1_sx[POS_W-1:FRAC_W];
    z0 = s1_sz[POS_W-1:FRAC_W];
    x_clamp = (x0 == GRID_BITS'(GRID_SIZE - 1));
    z_clamp = (z0 == GRID_BITS'(GRID_SIZE - 1));
    x1 = x_clamp ? x0 : x0 + 1'b1;
    z1 = z_clamp ? z0 : z0 + 1'b1;

    // Each parity bank reads whichever neighbor has its parity
    for (int p = 0; p < 2; p++) begin
      xc[p] = (x0[0] == 1'(p)) ? x0 : x1;
      zr[p] = (z0[0] == 1'(p)) ? z0 : z1;
    end
    for (int b = 0; b < BANKS; b++) begin
      rd_addr[b] = {zr[b/2][GRID_BITS-1:1], xc[b%2][GRID_BITS-1:1]};
    end

    sel.x0 = x0[0];
    sel.x1 = x_clamp ? x0[0] : ~x0[0];
    sel.z0 = z0[0];
    sel.z1 = z_clamp ? z0[0] : ~z0[0];
  end

  // Height banks: one write port shared, one registered read per bank
  for (genvar gb = 0; gb < BANKS; gb++) begin : g_bank
    logic signed [HGT_W-1:0] mem [BANK_DEPTH];
    logic signed [HGT_W-1:0] rd_q;

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == BANK_SEL_W'(gb))) begin
        mem[wr_addr] <= s1_wdata;
      end
      if (en2) begin
        rd_q <= mem[rd_addr[gb]];
      end
    end

    assign rd_data[gb] = rd_q;
  end

  // Latch grid_ready on the write of the last entry
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_ready <= 1'b0;
    end else if (wr_en && (32'(s1_idx) == CELL_COUNT - 1)) begin
      grid_ready <= 1'b1;
    end
  end

  // Advance queries into the read stage; writes end here
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid && (s1_op == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_dflt <= flat_mode || !grid_ready;
      s2_tx   <= s1_sx[FRAC_W-1:0];
      s2_tz   <= s1_sz[FRAC_W-1:0];
      s2_sel  <= sel;
    end
  end

  // Blend along x in both rows
  logic signed [HGT_W-1:0]  h00, h10, h01, h11;
  logic signed [SUM_W-1:0]  d0, d1;
  logic signed [FRAC_W:0]   tx_s;
  logic signed [ROW_W+1:0]  r0, r1;

  always_comb begin
    h00  = rd_data[{s2_sel.z0, s2_sel.x0}];
    h10  = rd_data[{s2_sel.z0, s2_sel.x1}];
    h01  = rd_data[{s2_sel.z1, s2_sel.x0}];
    h11  = rd_data[{s2_sel.z1, s2_sel.x1}];
    tx_s = $signed({1'b0, s2_tx});
    d0   = SUM_W'(h10) - SUM_W'(h00);
    d1   = SUM_W'(h11) - SUM_W'(h01);
    r0   = ((ROW_W + 2)'(h00) <<< FRAC_W) + (ROW_W + 2)'(d0 * tx_s);
    r1   = ((ROW_W + 2)'(h01) <<< FRAC_W) + (ROW_W + 2)'(d1 * tx_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_dflt <= s2_dflt;
      s3_tz   <= s2_tz;
      s3_r0   <= r0[ROW_W-1:0];
      s3_r1   <= r1[ROW_W-1:0];
    end
  end

  // Blend along z, round half up to an integer height
  logic signed [ROW_W:0]    dr;
  logic signed [FRAC_W:0]   tz_s;
  logic signed [FULL_W-1:0] full;
  logic signed [FULL_W-1:0] rnd;

  always_comb begin
    tz_s = $signed({1'b0, s3_tz});
    dr   = (ROW_W + 1)'(s3_r1) - (ROW_W + 1)'(s3_r0);
    full = (FULL_W'(s3_r0) <<< FRAC_W) + FULL_W'(dr * tz_s);
    rnd  = full + FULL_W'(1 << (2 * FRAC_W - 1));
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      height    <= s3_dflt ? '0 : rnd[2*FRAC_W+HGT_W-1:2*FRAC_W];
      defaulted <= s3_dflt;
    end
  end

endmodule

// ===== rtl/hbs_checker.sv =====
// Port-level checks for the heightmap bilinear sampler, bound to the top level.
module hbs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_we,
  input logic                             cfg_data,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             op,
  input logic        [hbs_pkg::IDX_W-1:0] sample_index,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [hbs_pkg::HGT_W-1:0] height,
  input logic                             defaulted
);
  import hbs_pkg::*;

  logic       flat_seen;
  logic       last_written;
  logic [2:0] pending;
  logic       q_acc;
  logic       o_acc;

  assign q_acc = in_valid && in_ready && (op == OP_QUERY);
  assign o_acc = out_valid && out_ready;

  // Track flat mode, the last-entry write and queries in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      flat_seen    <= 1'b0;
      last_written <= 1'b0;
      pending      <= '0;
    end else begin
      if (cfg_we) begin
        flat_seen <= cfg_data;
      end
      if (in_valid && in_ready && (op == OP_WRITE) &&
          (32'(sample_index) == CELL_COUNT - 1)) begin
        last_written <= 1'b1;
      end
      pending <= pending + 3'(q_acc) - 3'(o_acc);
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(height) && $stable(defaulted))
    else $error("result changed while stalled");

  // Every result answers an accepted query
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without a pending query");

  // A defaulted result carries zero height
  a_dflt_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && defaulted |-> height == '0)
    else $error("defaulted result with nonzero height");

  // Before the last entry is written every answer is defaulted
  a_unloaded: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_written |-> defaulted)
    else $error("answer from an unloaded grid");

  // Flat mode forces defaulted answers
  a_flat: assert property (@(posedge clk) disable iff (rst)
    out_valid && flat_seen |-> defaulted)
    else $error("answer in flat mode not defaulted");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (.*);
